FILE: sv/slpm_pkg.sv
`timescale 1ns / 1ps

package slpm_pkg;

  // Chunk geometry: a chunk holds this many segments.
  localparam int unsigned SEGMENTS    = 8;
  localparam int unsigned SEG_IDX_W   = $clog2(SEGMENTS);
  localparam int unsigned SEG_SHIFT   = $clog2(SEGMENTS);

  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned COUNT_W     = 16;
  localparam int unsigned PEAK_W      = 15;
  localparam int unsigned SUM_W       = 18;
  localparam int unsigned LEVEL_W     = SUM_W - SEG_SHIFT;
  localparam int unsigned BAR_W       = 7;
  localparam int unsigned PCT_W       = 8;

  // Level scaling: full scale is 2**FS_SHIFT.
  localparam int unsigned FS_SHIFT    = 14;
  localparam int unsigned PROD_W      = 22;
  localparam int unsigned BAR_MAX     = 70;
  localparam int unsigned PCT_SCALE   = 100;

  // APB register map
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned APB_DATA_W  = 32;
  localparam logic [COUNT_W-1:0] SEG_SAMPLES_RESET = 16'd2024;

  typedef enum logic [0:0] {
    REG_SEGMENT_SAMPLES = 1'b0
  } reg_idx_e;

  typedef struct packed {
    logic             level_valid;
    logic [BAR_W-1:0] bar_length;
    logic [PCT_W-1:0] level_percent;
  } level_t;

endpackage

FILE: sv/slpm_stream_if.sv
`timescale 1ns / 1ps

interface slpm_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [slpm_pkg::SAMPLE_W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface slpm_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [slpm_pkg::SAMPLE_W-1:0] sample_out;
  logic                               level_valid;
  logic [slpm_pkg::BAR_W-1:0]         bar_length;
  logic [slpm_pkg::PCT_W-1:0]         level_percent;

  modport source (output valid, output sample_out, output level_valid,
                  output bar_length, output level_percent, input ready);
  modport sink   (input valid, input sample_out, input level_valid,
                  input bar_length, input level_percent, output ready);
endinterface

FILE: sv/slpm_apb_regs.sv
`timescale 1ns / 1ps

module slpm_apb_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [slpm_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [slpm_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [slpm_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  output logic [slpm_pkg::COUNT_W-1:0]      seg_samples_o
);

  logic [slpm_pkg::COUNT_W-1:0] seg_samples_q;
  slpm_pkg::reg_idx_e           reg_idx;
  logic                         wr_en;

  // Registers are word aligned; only paddr[2] selects a register and the low address bits are ignored.
  assign reg_idx = slpm_pkg::reg_idx_e'(paddr[slpm_pkg::APB_ADDR_W-1]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_samples_q <= slpm_pkg::SEG_SAMPLES_RESET;
    end else if (wr_en && (reg_idx == slpm_pkg::REG_SEGMENT_SAMPLES)) begin
      seg_samples_q <= pwdata[slpm_pkg::COUNT_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      slpm_pkg::REG_SEGMENT_SAMPLES: begin
        prdata = {{(slpm_pkg::APB_DATA_W - slpm_pkg::COUNT_W){1'b0}}, seg_samples_q};
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  assign seg_samples_o = seg_samples_q;

endmodule

FILE: sv/slpm_meter.sv
`timescale 1ns / 1ps

module slpm_meter (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 step_i,
  input  logic signed [slpm_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [slpm_pkg::COUNT_W-1:0]         seg_samples_i,
  output slpm_pkg::level_t                     level_o
);

  logic [slpm_pkg::COUNT_W-1:0]   count_q;
  logic [slpm_pkg::SEG_IDX_W-1:0] seg_idx_q;
  logic [slpm_pkg::PEAK_W-1:0]    peak_q;
  logic [slpm_pkg::SUM_W-1:0]     sum_q;

  logic [slpm_pkg::PEAK_W-1:0]    peak_new;
  logic [slpm_pkg::COUNT_W-1:0]   limit;
  logic [slpm_pkg::COUNT_W:0]     taken;
  logic                           seg_close;
  logic                           chunk_last;
  logic [slpm_pkg::SUM_W-1:0]     sum_new;
  logic [slpm_pkg::LEVEL_W-1:0]   level;
  logic [slpm_pkg::PROD_W-1:0]    bar_prod;
  logic [slpm_pkg::PROD_W-1:0]    pct_prod;
  logic [slpm_pkg::PROD_W-slpm_pkg::FS_SHIFT-1:0] bar_raw;

  always_comb begin
    // Only non-negative samples can raise the segment peak.
    if (!sample_i[slpm_pkg::SAMPLE_W-1] &&
        (sample_i[slpm_pkg::PEAK_W-1:0] > peak_q)) begin
      peak_new = sample_i[slpm_pkg::PEAK_W-1:0];
    end else begin
      peak_new = peak_q;
    end

    // A size of zero behaves like one sample per segment.
    limit      = (seg_samples_i == '0) ? slpm_pkg::COUNT_W'(1) : seg_samples_i;
    taken      = {1'b0, count_q} + (slpm_pkg::COUNT_W+1)'(1);
    seg_close  = taken >= {1'b0, limit};
    chunk_last = seg_idx_q == slpm_pkg::SEG_IDX_W'(slpm_pkg::SEGMENTS - 1);
    sum_new    = sum_q + slpm_pkg::SUM_W'(peak_new);

    level    = sum_new[slpm_pkg::SUM_W-1:slpm_pkg::SEG_SHIFT];
    bar_prod = slpm_pkg::PROD_W'(level) * slpm_pkg::PROD_W'(slpm_pkg::BAR_MAX);
    pct_prod = slpm_pkg::PROD_W'(level) * slpm_pkg::PROD_W'(slpm_pkg::PCT_SCALE);
    bar_raw  = bar_prod[slpm_pkg::PROD_W-1:slpm_pkg::FS_SHIFT];

    level_o = '0;
    if (seg_close && chunk_last) begin
      level_o.level_valid = 1'b1;
      if (bar_raw > (slpm_pkg::PROD_W-slpm_pkg::FS_SHIFT)'(slpm_pkg::BAR_MAX)) begin
        level_o.bar_length = slpm_pkg::BAR_W'(slpm_pkg::BAR_MAX);
      end else begin
        level_o.bar_length = bar_raw[slpm_pkg::BAR_W-1:0];
      end
      level_o.level_percent = pct_prod[slpm_pkg::FS_SHIFT +: slpm_pkg::PCT_W]
                              + slpm_pkg::PCT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      seg_idx_q <= '0;
      peak_q    <= '0;
      sum_q     <= '0;
    end else if (step_i) begin
      if (seg_close) begin
        count_q <= '0;
        peak_q  <= '0;
        if (chunk_last) begin
          seg_idx_q <= '0;
          sum_q     <= '0;
        end else begin
          seg_idx_q <= seg_idx_q + slpm_pkg::SEG_IDX_W'(1);
          sum_q     <= sum_new;
        end
      end else begin
        count_q <= taken[slpm_pkg::COUNT_W-1:0];
        peak_q  <= peak_new;
      end
    end
  end

endmodule

FILE: sv/segmented_peak_level_meter_core.sv
`timescale 1ns / 1ps
// An accepted sample lands in the input register and then moves, with the level from
// the segment/level logic, into the output register that drives the output beat.
// Throughput: one sample per cycle while out_o.ready is high; the input register feeds
// the segment/level logic, whose result lands in the output register when that register is empty or being drained.
// Reset (rst_ni low, asynchronous) empties both stages, clears the segment counters,
// peak and sum, and sets segment_samples to 2024.
module segmented_peak_level_meter_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  slpm_in_if.sink                         in_i,
  slpm_out_if.source                      out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [slpm_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [slpm_pkg::APB_DATA_W-1:0] pwdata,
  output logic [slpm_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  logic [slpm_pkg::COUNT_W-1:0]          seg_samples;
  logic                                  s1_valid_q;
  logic signed [slpm_pkg::SAMPLE_W-1:0]  s1_sample_q;
  logic                                  out_valid_q;
  logic signed [slpm_pkg::SAMPLE_W-1:0]  out_sample_q;
  slpm_pkg::level_t                      out_level_q;
  slpm_pkg::level_t                      level;
  logic                                  in_beat;
  logic                                  s1_adv;

  slpm_apb_regs u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .seg_samples_o (seg_samples)
  );

  slpm_meter u_meter (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (s1_adv),
    .sample_i      (s1_sample_q),
    .seg_samples_i (seg_samples),
    .level_o       (level)
  );

  // The input stage moves on whenever the output register is empty or being drained.
  assign s1_adv   = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_beat  = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= in_beat || (s1_valid_q && !s1_adv);
      out_valid_q <= s1_adv || (out_valid_q && !out_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      s1_sample_q <= in_i.sample_in;
    end
    if (s1_adv) begin
      out_sample_q <= s1_sample_q;
      out_level_q  <= level;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.sample_out    = out_sample_q;
  assign out_o.level_valid   = out_level_q.level_valid;
  assign out_o.bar_length    = out_level_q.bar_length;
  assign out_o.level_percent = out_level_q.level_percent;

endmodule
